FILE: hdl/tpcu_pkg.sv
// Package for the tracker pattern cell unpacker.
// Holds the parser phase type, byte constants and the small decode functions.
// No dependencies.
package tpcu_pkg;

  // Parser phase: which byte of the current cell is expected next.
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_NOTE  = 3'd1,
    PH_INST  = 3'd2,
    PH_VOL   = 3'd3,
    PH_TYPE  = 3'd4,
    PH_PARAM = 3'd5
  } phase_t;

  localparam int unsigned TRACK_LIMIT = 32;

  localparam logic [5:0] TRACK_COUNT_RESET = 6'd4;
  localparam logic [5:0] TRACK_MAX         = 6'(TRACK_LIMIT < 32 ? TRACK_LIMIT : 32);

  localparam logic [7:0] MASK_FLAG     = 8'h80;
  localparam logic [4:0] FULL_FOLLOW   = 5'h1e;
  localparam logic [7:0] VOL_LOW       = 8'h10;
  localparam logic [7:0] VOL_HIGH      = 8'h50;
  localparam logic [7:0] CMD_VOLUME    = 8'h0c;
  localparam logic [6:0] NOTE_OFF_CODE = 7'h61;
  localparam logic [7:0] NOTE_OFF      = 8'd120;
  localparam logic [7:0] NOTE_NONE     = 8'd255;
  localparam logic [7:0] INST_NONE     = 8'd255;
  localparam logic [7:0] MACH_NORMAL   = 8'd0;
  localparam logic [7:0] MACH_EMPTY    = 8'd255;

  // Mask bit that belongs to a given phase.
  function automatic logic [4:0] phase_bit(input phase_t ph);
    logic [4:0] m;
    m = 5'b0;
    unique case (ph)
      PH_NOTE:  m = 5'b00001;
      PH_INST:  m = 5'b00010;
      PH_VOL:   m = 5'b00100;
      PH_TYPE:  m = 5'b01000;
      PH_PARAM: m = 5'b10000;
      default:  m = 5'b00000;
    endcase
    return m;
  endfunction

  // Phase of the lowest byte still pending in the mask.
  function automatic phase_t lowest_phase(input logic [4:0] mask);
    phase_t ph;
    ph = PH_LEAD;
    if (mask[0])      ph = PH_NOTE;
    else if (mask[1]) ph = PH_INST;
    else if (mask[2]) ph = PH_VOL;
    else if (mask[3]) ph = PH_TYPE;
    else if (mask[4]) ph = PH_PARAM;
    return ph;
  endfunction

  // Number of tracks actually used per row: zero acts as one, large values clamp.
  function automatic logic [5:0] eff_tracks(input logic [5:0] cnt);
    logic [5:0] n;
    n = cnt;
    if (n == 6'd0) n = 6'd1;
    if (n > TRACK_MAX) n = TRACK_MAX;
    return n;
  endfunction

endpackage

FILE: hdl/tracker_pattern_cell_unpacker_unit.sv
// Top level of the tracker pattern cell unpacker.
// Path: the last byte of a cell is taken into the input register; its translated cell
// then lands in the result register once that register is free or being emptied.
// Throughput: one item per cycle while results are taken; the parser state update is the only loop.
// A result left waiting at the output holds the byte in the input register, so input stalls too.
// Reset (rst, synchronous, active high) empties both registers, clears the parser and
// counters, and sets track_count to 4.
module tracker_pattern_cell_unpacker_unit (
  input  logic       clk,
  input  logic       rst,
  // Byte input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       pattern_start,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] note_out,
  output logic [7:0] instrument_out,
  output logic [7:0] machine_out,
  output logic [7:0] command_out,
  output logic [7:0] parameter_out,
  output logic [4:0] track_index,
  output logic [7:0] row_index,
  output logic       bad_note,
  // Configuration write channel: tracks per row.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  // Configuration register. Writes are always taken.
  logic [5:0] track_count;

  // Input register: one byte waiting to be parsed.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;

  // Parser state.
  tpcu_pkg::phase_t phase, phase_next;
  logic [4:0] pending_mask, pending_mask_next;
  logic [7:0] held_note, held_note_next;
  logic [7:0] held_instrument, held_instrument_next;
  logic [7:0] held_volume, held_volume_next;
  logic [7:0] held_effect_type, held_effect_type_next;
  logic [4:0] track_counter, track_counter_next;
  logic [7:0] row_counter, row_counter_next;

  // Values of the cell once this byte is applied.
  logic [7:0] cell_note, cell_inst, cell_vol, cell_type, cell_param;
  logic [4:0] cell_mask;
  logic [4:0] pos_track;
  logic [7:0] pos_row;
  logic       emit;

  // Translated result.
  logic [7:0] res_note, res_inst, res_cmd, res_par, res_mach;
  logic       res_bad;
  logic [6:0] note7;
  logic [7:0] vol_off;
  logic [5:0] track_inc;

  // The input register moves on whenever the result register is free or being emptied.
  // A finished result waiting at the output keeps the byte in the input register and
  // drops in_ready until the result is taken.
  logic advance;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  // Parse one byte. A pattern start clears the parser and the counters first,
  // so the byte is always read as a lead byte in that case.
  always_comb begin
    tpcu_pkg::phase_t ph;
    ph         = in_start ? tpcu_pkg::PH_LEAD : phase;
    pos_track  = in_start ? 5'd0 : track_counter;
    pos_row    = in_start ? 8'd0 : row_counter;
    cell_note  = held_note;
    cell_inst  = held_instrument;
    cell_vol   = held_volume;
    cell_type  = held_effect_type;
    cell_param = 8'd0;
    cell_mask  = pending_mask;
    if (ph == tpcu_pkg::PH_LEAD) begin
      // A lead byte begins a fresh cell.
      cell_inst = tpcu_pkg::INST_NONE;
      cell_vol  = 8'd0;
      cell_type = 8'd0;
      if ((in_byte & tpcu_pkg::MASK_FLAG) != 8'd0) begin
        cell_note = 8'd0;
        cell_mask = in_byte[4:0];
      end else begin
        cell_note = in_byte;
        cell_mask = tpcu_pkg::FULL_FOLLOW;
      end
    end else begin
      unique case (ph)
        tpcu_pkg::PH_NOTE:  cell_note  = in_byte;
        tpcu_pkg::PH_INST:  cell_inst  = in_byte;
        tpcu_pkg::PH_VOL:   cell_vol   = in_byte;
        tpcu_pkg::PH_TYPE:  cell_type  = in_byte;
        tpcu_pkg::PH_PARAM: cell_param = in_byte;
        default:            cell_param = 8'd0;
      endcase
      cell_mask = pending_mask & ~tpcu_pkg::phase_bit(ph);
    end
    emit = (cell_mask == 5'd0);
  end

  // Next parser state: a completed cell returns the parser to the lead byte.
  always_comb begin
    track_inc = {1'b0, pos_track} + 6'd1;
    if (emit) begin
      phase_next            = tpcu_pkg::PH_LEAD;
      pending_mask_next     = 5'd0;
      held_note_next        = 8'd0;
      held_instrument_next  = tpcu_pkg::INST_NONE;
      held_volume_next      = 8'd0;
      held_effect_type_next = 8'd0;
      // The counter can never pass 32 tracks, so reaching 32 also wraps it.
      if (track_inc >= tpcu_pkg::eff_tracks(track_count)) begin
        track_counter_next = 5'd0;
        row_counter_next   = pos_row + 8'd1;
      end else begin
        track_counter_next = track_inc[4:0];
        row_counter_next   = pos_row;
      end
    end else begin
      phase_next            = tpcu_pkg::lowest_phase(cell_mask);
      pending_mask_next     = cell_mask;
      held_note_next        = cell_note;
      held_instrument_next  = cell_inst;
      held_volume_next      = cell_vol;
      held_effect_type_next = cell_type;
      track_counter_next    = pos_track;
      row_counter_next      = pos_row;
    end
  end

  // Cell translation: volume to command, note transposition, empty-cell marking.
  always_comb begin
    note7   = cell_note[6:0];
    vol_off = cell_vol - tpcu_pkg::VOL_LOW;
    if (cell_vol >= tpcu_pkg::VOL_LOW && cell_vol <= tpcu_pkg::VOL_HIGH) begin
      res_cmd = tpcu_pkg::CMD_VOLUME;
      // Four times the offset, low eight bits only: the top volume wraps to zero.
      res_par = {vol_off[5:0], 2'b00};
    end else begin
      res_cmd = cell_type;
      res_par = cell_param;
    end
    res_inst = cell_inst;
    res_bad  = 1'b0;
    if (note7 == 7'd0) begin
      res_note = tpcu_pkg::NOTE_NONE;
    end else if (note7 == tpcu_pkg::NOTE_OFF_CODE) begin
      res_note = tpcu_pkg::NOTE_OFF;
      res_inst = tpcu_pkg::INST_NONE;
    end else if (note7 >= 7'd30) begin
      res_note = {1'b0, note7 - 7'd30};
    end else if (note7 >= 7'd18) begin
      res_note = {1'b0, note7 - 7'd18};
    end else if (note7 >= 7'd6) begin
      res_note = {1'b0, note7 - 7'd6};
    end else begin
      // Notes one to five sit below the lowest transposable octave.
      res_note = tpcu_pkg::NOTE_NONE;
      res_bad  = 1'b1;
    end
    if (res_note == tpcu_pkg::NOTE_NONE && res_cmd == 8'd0 && res_par == 8'd0 &&
        res_inst == tpcu_pkg::INST_NONE) begin
      res_mach = tpcu_pkg::MACH_EMPTY;
    end else begin
      res_mach = tpcu_pkg::MACH_NORMAL;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      track_count <= tpcu_pkg::TRACK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      track_count <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= data_byte;
      in_start <= pattern_start;
    end
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tpcu_pkg::PH_LEAD;
      pending_mask     <= 5'd0;
      held_note        <= 8'd0;
      held_instrument  <= tpcu_pkg::INST_NONE;
      held_volume      <= 8'd0;
      held_effect_type <= 8'd0;
      track_counter    <= 5'd0;
      row_counter      <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      pending_mask     <= pending_mask_next;
      held_note        <= held_note_next;
      held_instrument  <= held_instrument_next;
      held_volume      <= held_volume_next;
      held_effect_type <= held_effect_type_next;
      track_counter    <= track_counter_next;
      row_counter      <= row_counter_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      note_out       <= res_note;
      instrument_out <= res_inst;
      machine_out    <= res_mach;
      command_out    <= res_cmd;
      parameter_out  <= res_par;
      track_index    <= pos_track;
      row_index      <= pos_row;
      bad_note       <= res_bad;
    end
  end

  // While a cell is open, its expected byte must still be pending in the mask.
  a_phase_in_mask: assert property (@(posedge clk) disable iff (rst)
    phase != tpcu_pkg::PH_LEAD |-> (pending_mask & tpcu_pkg::phase_bit(phase)) != 5'd0)
    else $error("parser phase has no pending byte");

  // A result that is not taken stays valid with its fields unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(note_out) && $stable(track_index) &&
      $stable(row_index))
    else $error("waiting result changed before it was taken");

  // An empty cell has neither a note nor an instrument.
  a_empty_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && machine_out == tpcu_pkg::MACH_EMPTY |->
      note_out == tpcu_pkg::NOTE_NONE && instrument_out == tpcu_pkg::INST_NONE)
    else $error("empty cell carries note or instrument");

  // An untransposable note never yields a note value.
  a_bad_note: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_note |-> note_out == tpcu_pkg::NOTE_NONE)
    else $error("bad note with a note value");

endmodule

FILE: sim/tb_top.sv
// Testbench for the tracker pattern cell unpacker: a directed table of packed bytes
// followed by random cell sequences, checked against a cycle-free predictor.
// Depends on tpcu_pkg and tracker_pattern_cell_unpacker_unit.
`timescale 1ns / 1ps

module tb_top;

  // One translated cell, laid out in the order of the result ports.
  typedef struct packed {
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] mach;
    logic [7:0] cmd;
    logic [7:0] par;
    logic [4:0] track;
    logic [7:0] row;
    logic       bad;
  } cell_t;

  // A row of the directed table. Rows with typed set carry the cell that the
  // byte completes, written out by hand; the others rely on the predictor.
  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       typed;
    cell_t      want;
  } step_t;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_DIRECTED  = 25;
  localparam int N_PHASES    = 6;

  localparam logic [5:0] FIXED_TRACKS [4] = '{6'd1, 6'd32, 6'd0, 6'd63};

  // Track count is at its reset value of 4 throughout this table.
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // Empty mask right after reset: the whole cell is empty.
    '{8'h80, 1'b1, 1'b1,
      '{tpcu_pkg::NOTE_NONE, tpcu_pkg::INST_NONE, tpcu_pkg::MACH_EMPTY, 8'h00, 8'h00,
        5'd0, 8'd0, 1'b0}},
    // Unpacked note-off cell, volume 0x50 wraps the parameter to zero.
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},
    '{8'h0f, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b1,
      '{tpcu_pkg::NOTE_OFF, tpcu_pkg::INST_NONE, tpcu_pkg::MACH_NORMAL, tpcu_pkg::CMD_VOLUME,
        8'h00, 5'd1, 8'd0, 1'b0}},
    // Note only, and too low to transpose.
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b1,
      '{tpcu_pkg::NOTE_NONE, tpcu_pkg::INST_NONE, tpcu_pkg::MACH_EMPTY, 8'h00, 8'h00,
        5'd2, 8'd0, 1'b1}},
    // Full mask with the unused bits set; note byte with bit 7 set.
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h10, 1'b0, 1'b0, '0},
    '{8'haa, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    // Volume just below the range, zero effect: first cell of row 1.
    '{8'h9c, 1'b0, 1'b0, '0},
    '{8'h0f, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    // Volume only, just above the range.
    '{8'he4, 1'b0, 1'b0, '0},
    '{8'h51, 1'b0, 1'b0, '0},
    // New pattern: unpacked note 30, top of the volume range minus one.
    '{8'h1e, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h4f, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  logic       clk;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte     = 8'h00;
  logic       pattern_start = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] note_out;
  logic [7:0] instrument_out;
  logic [7:0] machine_out;
  logic [7:0] command_out;
  logic [7:0] parameter_out;
  logic [4:0] track_index;
  logic [7:0] row_index;
  logic       bad_note;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data      = 6'd0;

  // Predictor state: parser, held bytes, position counters and the register.
  tpcu_pkg::phase_t cur_phase;
  logic [4:0] pend_bits;
  logic [7:0] h_note, h_inst, h_vol, h_type;
  logic [4:0] trk_ctr;
  logic [7:0] row_ctr;
  logic [5:0] trk_count;

  cell_t cells_due [$];
  int    fails       = 0;
  int    bytes_sent  = 0;
  int    cycle_count = 0;
  bit    steady_run  = 1'b0;

  tracker_pattern_cell_unpacker_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .pattern_start  (pattern_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .note_out       (note_out),
    .instrument_out (instrument_out),
    .machine_out    (machine_out),
    .command_out    (command_out),
    .parameter_out  (parameter_out),
    .track_index    (track_index),
    .row_index      (row_index),
    .bad_note       (bad_note),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Back to the lead byte with nothing held.
  function automatic void clear_held();
    cur_phase = tpcu_pkg::PH_LEAD;
    pend_bits = 5'd0;
    h_note    = 8'h00;
    h_inst    = tpcu_pkg::INST_NONE;
    h_vol     = 8'h00;
    h_type    = 8'h00;
  endfunction

  // Feeds one byte to the predictor; done tells whether it completed a cell.
  task automatic unpack_byte(input logic [7:0] b, input logic s, output bit done,
                             output cell_t c);
    logic [7:0] par_byte;
    logic [6:0] note7;
    logic [5:0] eff;
    par_byte = 8'h00;
    done     = 1'b0;
    c        = '0;
    if (s) begin
      clear_held();
      trk_ctr = 5'd0;
      row_ctr = 8'd0;
    end
    if (cur_phase == tpcu_pkg::PH_LEAD) begin
      clear_held();
      if (b[7]) begin
        // Presence mask; bits 5 and 6 carry nothing.
        pend_bits = b[4:0];
      end else begin
        h_note    = b;
        pend_bits = tpcu_pkg::FULL_FOLLOW;
      end
    end else begin
      case (cur_phase)
        tpcu_pkg::PH_NOTE: h_note   = b;
        tpcu_pkg::PH_INST: h_inst   = b;
        tpcu_pkg::PH_VOL:  h_vol    = b;
        tpcu_pkg::PH_TYPE: h_type   = b;
        default:           par_byte = b;
      endcase
      pend_bits[cur_phase - 1] = 1'b0;
    end

    if (pend_bits != 5'd0) begin
      // Next expected byte is the lowest one still missing.
      for (int i = 4; i >= 0; i--) begin
        if (pend_bits[i]) cur_phase = tpcu_pkg::phase_t'(i + 1);
      end
    end else begin
      done = 1'b1;
      if (h_vol >= tpcu_pkg::VOL_LOW && h_vol <= tpcu_pkg::VOL_HIGH) begin
        c.cmd = tpcu_pkg::CMD_VOLUME;
        c.par = (h_vol - tpcu_pkg::VOL_LOW) << 2;
      end else begin
        c.cmd = h_type;
        c.par = par_byte;
      end
      note7  = h_note[6:0];
      c.inst = h_inst;
      c.bad  = 1'b0;
      // Transpose down by 30, 18 or 6 depending on the range the note falls in.
      if (note7 == 7'd0) begin
        c.note = tpcu_pkg::NOTE_NONE;
      end else if (note7 == tpcu_pkg::NOTE_OFF_CODE) begin
        c.note = tpcu_pkg::NOTE_OFF;
        c.inst = tpcu_pkg::INST_NONE;
      end else if (note7 >= 7'd30) begin
        c.note = note7 - 7'd30;
      end else if (note7 >= 7'd18) begin
        c.note = note7 - 7'd18;
      end else if (note7 >= 7'd6) begin
        c.note = note7 - 7'd6;
      end else begin
        c.note = tpcu_pkg::NOTE_NONE;
        c.bad  = 1'b1;
      end
      c.mach = (c.note == tpcu_pkg::NOTE_NONE && c.cmd == 8'h00 && c.par == 8'h00 &&
                c.inst == tpcu_pkg::INST_NONE) ? tpcu_pkg::MACH_EMPTY : tpcu_pkg::MACH_NORMAL;
      c.track = trk_ctr;
      c.row   = row_ctr;

      eff = (trk_count == 6'd0) ? 6'd1 : trk_count;
      if (eff > tpcu_pkg::TRACK_MAX) eff = tpcu_pkg::TRACK_MAX;
      trk_ctr = trk_ctr + 5'd1;
      if (trk_ctr == 5'd0 || trk_ctr >= eff) begin
        trk_ctr = 5'd0;
        row_ctr = row_ctr + 8'd1;
      end
      clear_held();
    end
  endtask

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_note();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return {1'($urandom), tpcu_pkg::NOTE_OFF_CODE};
    if (r < 30) return 8'($urandom_range(1, 5));
    if (r < 40) begin
      case ($urandom_range(0, 5))
        0: return 8'd6;
        1: return 8'd17;
        2: return 8'd18;
        3: return 8'd29;
        4: return 8'd30;
        default: return 8'h7f;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_vol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(tpcu_pkg::VOL_LOW, tpcu_pkg::VOL_HIGH));
    if (r < 60) return tpcu_pkg::VOL_LOW + {7'd0, 1'($urandom)} - 8'd1;
    if (r < 70) return tpcu_pkg::VOL_HIGH + {7'd0, 1'($urandom)};
    if (r < 85) return 8'h00;
    return 8'($urandom);
  endfunction

  // Instrument, effect type and parameter: zeros and 0xFF are frequent so that
  // fully empty cells come up often.
  function automatic logic [7:0] pick_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h00;
    if (r < 40) return 8'hff;
    return 8'($urandom);
  endfunction

  // Drives one item on the byte channel and waits for it to be taken. The
  // predictor runs at the edge that accepts it. A typed expectation from the
  // directed table takes the place of the predicted cell.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed = 1'b0,
                           input cell_t want = '0);
    int    gap;
    bit    done;
    cell_t c;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    pattern_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    unpack_byte(b, s, done, c);
    if (typed) cells_due.push_back(want);
    else if (done) cells_due.push_back(c);
  endtask

  // One random cell in packed form, or now and then a few raw bytes that
  // break cells up, with a new pattern often starting in the middle of one.
  task automatic send_random_cell(input int empty_pct, input bit allow_start);
    int         kind;
    int         extra;
    logic [4:0] m;
    logic [7:0] nb;
    logic       s;
    s    = allow_start && ($urandom_range(0, 39) == 0);
    kind = $urandom_range(0, 99);
    if (kind < empty_pct) begin
      send_byte({1'b1, 2'($urandom), 5'd0}, s);
    end else if (kind < empty_pct + 6) begin
      extra = $urandom_range(1, 3);
      repeat (extra) send_byte(8'($urandom), allow_start && ($urandom_range(0, 2) == 0));
    end else if ($urandom_range(0, 2) == 0) begin
      nb = pick_note();
      send_byte({1'b0, nb[6:0]}, s);
      send_byte(pick_field(), 1'b0);
      send_byte(pick_vol(), 1'b0);
      send_byte(pick_field(), 1'b0);
      send_byte(pick_field(), 1'b0);
    end else begin
      m = 5'($urandom);
      send_byte({1'b1, 2'($urandom), m}, s);
      if (m[0]) send_byte(pick_note(), 1'b0);
      if (m[1]) send_byte(pick_field(), 1'b0);
      if (m[2]) send_byte(pick_vol(), 1'b0);
      if (m[3]) send_byte(pick_field(), 1'b0);
      if (m[4]) send_byte(pick_field(), 1'b0);
    end
  endtask

  // Writes the tracks-per-row register once the block has gone quiet. A byte
  // that completes no cell may still be inside, so the clock runs on before the write.
  task automatic write_tracks(input logic [5:0] v);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    trk_count = v;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // Result side: the ready line alternates runs of high and low, except in
  // the steady phase where it stays high.
  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (steady_run || $urandom_range(0, 1) == 1) begin
        out_ready <= 1'b1;
        span = steady_run ? 1 : $urandom_range(1, 24);
      end else begin
        out_ready <= 1'b0;
        span = idle_span();
        if (span == 0) span = 1;
      end
      repeat (span) @(posedge clk);
    end
  end

  // Every result taken is compared with the oldest cell still expected.
  always @(posedge clk) begin : result_check
    cell_t due;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (cells_due.size() == 0) begin
        $display("%0t: result with no cell expected, note %0d track %0d row %0d",
                 $time, note_out, track_index, row_index);
        fails++;
      end else begin
        due = cells_due.pop_front();
        check_field("note_out", due.note, note_out);
        check_field("instrument_out", due.inst, instrument_out);
        check_field("machine_out", due.mach, machine_out);
        check_field("command_out", due.cmd, command_out);
        check_field("parameter_out", due.par, parameter_out);
        check_field("track_index", {3'd0, due.track}, {3'd0, track_index});
        check_field("row_index", due.row, row_index);
        check_field("bad_note", {7'd0, due.bad}, {7'd0, bad_note});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int         n;
    int         p;
    int         goal;
    logic [5:0] tracks;
    trk_count = tpcu_pkg::TRACK_COUNT_RESET;
    clear_held();
    trk_ctr = 5'd0;
    row_ctr = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) begin
      send_byte(DIRECTED[n].b, DIRECTED[n].s, DIRECTED[n].typed, DIRECTED[n].want);
    end

    // Random phases. The first runs one track per row, mostly one-byte empty
    // cells and no pattern start, long enough for the row counter to wrap.
    // The second runs with neither side ever idle.
    for (p = 0; p < N_PHASES; p++) begin
      if (p < 4) tracks = FIXED_TRACKS[p];
      else if (p == 4) tracks = 6'($urandom_range(2, 31));
      else tracks = 6'($urandom_range(0, 63));
      write_tracks(tracks);
      steady_run = (p == 1);
      goal = bytes_sent + ((p == 0) ? 450 : 300);
      while (bytes_sent < goal) begin
        send_random_cell((p == 0) ? 85 : 15, p != 0);
      end
    end
    steady_run = 1'b0;

    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
